### hw/rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scan debouncer
// Widths of the scan fields, the count and the result fields, and the
// mapping from a matrix position to a key number.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int ROW_BITS = 4;   // row bits carried per column field
  localparam int IN_COLS  = 3;   // column fields in one scan
  localparam int CNT_W    = 8;   // stable count and threshold width
  localparam int LOW_W    = 6;   // lowest-key index, covers up to 64 keys
  localparam int IDX_W    = 4;   // key_index port width
  localparam int CODE_W   = 6;   // key_code port width

  localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
  localparam logic [CNT_W-1:0]  THRESH_RESET  = CNT_W'(7);
  localparam logic [CODE_W-1:0] ASCII_ZERO    = CODE_W'(48);

  typedef logic [ROW_BITS-1:0] rows_t;

  // Key number of row r, column c: raster order from 1, then the
  // next-to-last key becomes 0 and the last key takes its place.
  function automatic int key_number(int r, int c, int num_cols, int keys);
    int n;
    n = r * num_cols + c + 1;
    if (n == keys - 1 && keys > 1) begin
      n = 0;
    end else if (n == keys) begin
      n = keys - 1;
    end
    return n;
  endfunction

endpackage

### hw/rtl/kpd_lane.sv
// ----------------------------------------------------------------------------
// kpd_lane: one column lane
// Maps the row bits read on one driven column onto the key vector.
// ----------------------------------------------------------------------------
module kpd_lane #(
  parameter int COL      = 0,
  parameter int NUM_ROWS = 4,
  parameter int NUM_COLS = 3,
  parameter int KEYS     = NUM_ROWS * NUM_COLS
) (
  input  kpd_pkg::rows_t    rows,
  output logic [KEYS-1:0]   keys
);
  import kpd_pkg::*;

  always_comb begin
    keys = '0;
    for (int r = 0; r < NUM_ROWS && r < ROW_BITS; r++) begin
      if (rows[r]) begin
        keys[key_number(r, COL, NUM_COLS, KEYS)] = 1'b1;
      end
    end
  end

endmodule

### hw/rtl/kpd_core.sv
// ----------------------------------------------------------------------------
// kpd_core: merge and debounce
// ORs the lane vectors into one scan, tracks the reference vector and the
// stable count, and registers the accepted key for the output channel.
// ----------------------------------------------------------------------------
module kpd_core #(
  parameter int NUM_ROWS = 4,
  parameter int NUM_COLS = 3,
  parameter int KEYS     = NUM_ROWS * NUM_COLS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [kpd_pkg::IN_COLS-1:0][KEYS-1:0] lane_keys,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kpd_pkg::IDX_W-1:0]             key_index,
  output logic [kpd_pkg::CODE_W-1:0]            key_code,
  input  logic                                  cfg_wr_en,
  input  logic [kpd_pkg::CNT_W-1:0]             cfg_wr_data
);
  import kpd_pkg::*;

  logic [KEYS-1:0]   ref_keys;
  logic [CNT_W-1:0]  stable_count;
  logic [CNT_W-1:0]  threshold;
  logic [KEYS-1:0]   scan;
  logic [LOW_W-1:0]  low_idx;
  logic              accept;
  logic              match;
  logic              fire;

  // Merge stage: each key belongs to exactly one lane
  always_comb begin
    scan = '0;
    for (int c = 0; c < IN_COLS; c++) begin
      scan = scan | lane_keys[c];
    end
  end

  // Lowest pressed key of the reference; empty reads as 0
  always_comb begin
    low_idx = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (ref_keys[i]) begin
        low_idx = LOW_W'(i);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign match    = (scan == ref_keys) && (|ref_keys);
  assign fire     = !match && (stable_count > threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_keys     <= '0;
      stable_count <= '0;
      threshold    <= THRESH_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (accept) begin
        if (match) begin
          if (stable_count != COUNT_MAX) begin
            stable_count <= stable_count + CNT_W'(1);
          end
        end else if (fire) begin
          // drop the new scan, start over from an empty reference
          ref_keys     <= '0;
          stable_count <= '0;
        end else begin
          ref_keys     <= scan;
          stable_count <= '0;
        end
      end
      if (accept && fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      key_index <= low_idx[IDX_W-1:0];
      key_code  <= low_idx + ASCII_ZERO;
    end
  end

endmodule

### hw/rtl/keypad_scan_debounce.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce: matrix keypad scan debouncer
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   in       | in_valid / in_ready  | col0_rows, col1_rows, col2_rows
//   out      | out_valid/ out_ready | key_index, key_code
//   cfg      | cfg_wr_en            | cfg_wr_data (stable_threshold)
//
// One scan request is taken every cycle while in_ready is high; the column
// lanes, merge, compare, count update and priority encode are combinational.
// A result is registered and shows in the cycle after the request that made it.
// in_ready drops only while a result waits and out_ready is low.
// Synchronous reset clears the reference, the count and the output valid,
// and sets the threshold to 7.
// ----------------------------------------------------------------------------
module keypad_scan_debounce #(
  parameter int NUM_ROWS = 4,
  parameter int NUM_COLS = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kpd_pkg::rows_t              col0_rows,
  input  kpd_pkg::rows_t              col1_rows,
  input  kpd_pkg::rows_t              col2_rows,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kpd_pkg::IDX_W-1:0]   key_index,
  output logic [kpd_pkg::CODE_W-1:0]  key_code,
  input  logic                        cfg_wr_en,
  input  logic [kpd_pkg::CNT_W-1:0]   cfg_wr_data
);
  import kpd_pkg::*;

  localparam int KEYS = NUM_ROWS * NUM_COLS;

  rows_t [IN_COLS-1:0]              col_rows;
  logic  [IN_COLS-1:0][KEYS-1:0]    lane_keys;

  assign col_rows = {col2_rows, col1_rows, col0_rows};

  for (genvar c = 0; c < IN_COLS; c++) begin : g_lane
    if (c < NUM_COLS) begin : g_used
      kpd_lane #(
        .COL      (c),
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS),
        .KEYS     (KEYS)
      ) u_lane (
        .rows (col_rows[c]),
        .keys (lane_keys[c])
      );
    end else begin : g_unused
      // column not present in this matrix
      assign lane_keys[c] = '0;
    end
  end

  kpd_core #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS),
    .KEYS     (KEYS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .lane_keys   (lane_keys),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_index   (key_index),
    .key_code    (key_code),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

### hw/rtl/kpd_checker.sv
// ----------------------------------------------------------------------------
// kpd_checker: port-level checks for the keypad scan debouncer
// Watches the top-level ports and is bound onto every instance.
// ----------------------------------------------------------------------------
module kpd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kpd_pkg::IDX_W-1:0]   key_index,
  input logic [kpd_pkg::CODE_W-1:0]  key_code
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_index) && $stable(key_code))
    else $error("result changed or dropped while stalled");

  // a new result comes only from the request accepted the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a preceding request");

  // input stalls only under output backpressure
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keypad_scan_debounce kpd_checker u_kpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_index (key_index),
  .key_code  (key_code)
);
